[rtl/usart_pkg.sv]
// Shared types, codes and queue-pointer helpers for the USART register model.
// No dependencies; imported by usart_exec, usart_register_model and the testbench.
package usart_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PTR_W       = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned FILL_W      = PTR_W + 1;
  localparam int unsigned DIV_W       = 21;

  // Event codes carried in tuser
  localparam logic [2:0] MODE_READ      = 3'd0;
  localparam logic [2:0] MODE_WRITE     = 3'd1;
  localparam logic [2:0] MODE_RX_BYTE   = 3'd2;
  localparam logic [2:0] MODE_RX_HOLD   = 3'd3;
  localparam logic [2:0] MODE_TX_TIMER  = 3'd4;
  localparam logic [2:0] MODE_LINE_PULL = 3'd5;
  localparam logic [2:0] MODE_TXC_ACK   = 3'd6;

  // Register offsets
  localparam logic [2:0] ADDR_STATUS  = 3'd0;
  localparam logic [2:0] ADDR_CONTROL = 3'd1;
  localparam logic [2:0] ADDR_FRAME   = 3'd2;
  localparam logic [2:0] ADDR_BAUD_LO = 3'd4;
  localparam logic [2:0] ADDR_BAUD_HI = 3'd5;
  localparam logic [2:0] ADDR_DATA    = 3'd6;

  // Status bits
  localparam int unsigned ST_RXC  = 7;
  localparam int unsigned ST_TXC  = 6;
  localparam int unsigned ST_UDRE = 5;
  localparam int unsigned ST_DOR  = 3;
  localparam int unsigned ST_U2X  = 1;
  // Control bits
  localparam int unsigned CT_RXCIE = 7;
  localparam int unsigned CT_TXCIE = 6;
  localparam int unsigned CT_UDRIE = 5;
  localparam int unsigned CT_RXEN  = 4;
  localparam int unsigned CT_TXEN  = 3;

  localparam logic [7:0] FRAME_RESET = 8'd6;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_char;
  } item_t;

  typedef struct packed {
    logic [7:0]       status;
    logic [7:0]       control;
    logic [7:0]       frame;
    logic [7:0]       baud_lo;
    logic [7:0]       baud_hi;
    logic [7:0]       rx_data;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    logic             listen;
    logic             line;
  } regs_t;

  typedef struct packed {
    logic [DIV_W-1:0] baud_divisor;
    logic             start_rx_timer;
    logic             start_tx_timer;
    logic             rx_listening;
    logic             tx_line_active;
    logic [7:0]       tx_char;
    logic             tx_char_valid;
    logic             udre_irq;
    logic             tx_irq;
    logic             rx_irq;
    logic [7:0]       read_data;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [7:0]        data;
  } qwrite_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(2 * QUEUE_DEPTH - 1)) r = '0;
    else                                   r = p + PTR_W'(1);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    if (p >= PTR_W'(QUEUE_DEPTH)) t = p - PTR_W'(QUEUE_DEPTH);
    else                           t = p;
    return t[SLOT_W-1:0];
  endfunction

endpackage

[rtl/usart_txq_ram.sv]
// Generic single-write, single-read synchronous RAM holding the transmit queue.
// No package dependency; read data is registered.
module usart_txq_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/usart_exec.sv]
// Read-modify-write step of the register file: next registers, result and
// queue write for one event. Depends on usart_pkg.
module usart_exec (
  input  usart_pkg::item_t   item_i,
  input  usart_pkg::regs_t   regs_i,
  input  logic [7:0]         q_rdata_i,
  output usart_pkg::regs_t   regs_o,
  output usart_pkg::result_t res_o,
  output usart_pkg::qwrite_t qwr_o
);
  import usart_pkg::*;

  logic [FILL_W-1:0] fill;
  logic              full;
  logic [7:0]        diff;
  logic [16:0]       baud_p1;
  regs_t             n;

  always_comb begin
    if (regs_i.wr_ptr >= regs_i.rd_ptr) begin
      fill = {1'b0, regs_i.wr_ptr} - {1'b0, regs_i.rd_ptr};
    end else begin
      fill = {1'b0, regs_i.wr_ptr} + FILL_W'(2 * QUEUE_DEPTH) - {1'b0, regs_i.rd_ptr};
    end
    full = (fill >= FILL_W'(QUEUE_DEPTH));
  end

  always_comb begin
    n    = regs_i;
    diff = regs_i.control ^ item_i.write_data;
    res_o = '0;
    qwr_o.we   = 1'b0;
    qwr_o.addr = ptr_slot(regs_i.wr_ptr);
    qwr_o.data = item_i.write_data;

    case (item_i.mode)
      MODE_READ: begin
        case (item_i.reg_addr)
          ADDR_STATUS:  res_o.read_data = regs_i.status;
          ADDR_CONTROL: res_o.read_data = regs_i.control;
          ADDR_FRAME:   res_o.read_data = regs_i.frame;
          ADDR_BAUD_LO: res_o.read_data = regs_i.baud_lo;
          ADDR_BAUD_HI: res_o.read_data = regs_i.baud_hi;
          ADDR_DATA: begin
            res_o.read_data = regs_i.rx_data;
            n.status[ST_RXC] = 1'b0;
            if (regs_i.control[CT_RXEN]) n.listen = 1'b1;
          end
          default: res_o.read_data = 8'h00;
        endcase
      end
      MODE_WRITE: begin
        case (item_i.reg_addr)
          ADDR_STATUS: n.status = {3'b000, item_i.write_data[4:0]};
          ADDR_CONTROL: begin
            n.control = item_i.write_data;
            if (item_i.write_data[CT_TXEN] && diff[CT_TXEN]) n.status[ST_UDRE] = 1'b1;
            if (diff[CT_RXEN]) n.listen = item_i.write_data[CT_RXEN];
          end
          ADDR_FRAME:   n.frame   = item_i.write_data;
          ADDR_BAUD_LO: n.baud_lo = item_i.write_data;
          ADDR_BAUD_HI: n.baud_hi = item_i.write_data;
          ADDR_DATA: begin
            // Push only when the data register is empty and the queue has room
            if (regs_i.status[ST_UDRE] && !full) begin
              n.status[ST_TXC]  = 1'b0;
              n.status[ST_UDRE] = 1'b0;
              n.line            = 1'b1;
              n.wr_ptr          = ptr_next(regs_i.wr_ptr);
              qwr_o.we          = 1'b1;
              res_o.start_tx_timer = 1'b1;
            end
          end
          default: n = regs_i;
        endcase
      end
      MODE_RX_BYTE: begin
        if (regs_i.status[ST_RXC]) begin
          n.status[ST_DOR] = 1'b1;
        end else begin
          n.rx_data        = item_i.rx_char;
          n.status[ST_RXC] = 1'b1;
        end
        n.listen = 1'b0;
        res_o.start_rx_timer = 1'b1;
      end
      MODE_RX_HOLD: begin
        if (regs_i.control[CT_RXEN]) n.listen = 1'b1;
      end
      MODE_TX_TIMER: begin
        if (full) begin
          res_o.start_tx_timer = 1'b1;
        end else begin
          n.status[ST_UDRE] = 1'b1;
          n.status[ST_TXC]  = 1'b1;
        end
      end
      MODE_LINE_PULL: begin
        if (fill != '0) begin
          res_o.tx_char_valid = 1'b1;
          res_o.tx_char       = q_rdata_i;
          n.rd_ptr            = ptr_next(regs_i.rd_ptr);
        end
        // Drop the line once the queue is drained (after this pop, if any)
        if (fill <= FILL_W'(1)) n.line = 1'b0;
      end
      MODE_TXC_ACK: n.status[ST_TXC] = 1'b0;
      default: n = regs_i;
    endcase

    baud_p1 = {1'b0, n.baud_hi, n.baud_lo} + 17'd1;
    res_o.baud_divisor = n.status[ST_U2X] ? {1'b0, baud_p1, 3'b000} : {baud_p1, 4'b0000};
    res_o.rx_irq         = n.status[ST_RXC]  & n.control[CT_RXCIE];
    res_o.tx_irq         = n.status[ST_TXC]  & n.control[CT_TXCIE];
    res_o.udre_irq       = n.status[ST_UDRE] & n.control[CT_UDRIE];
    res_o.tx_line_active = n.line;
    res_o.rx_listening   = n.listen;
    regs_o = n;
  end

endmodule

[rtl/usart_register_model.sv]
// Top level of the USART register model: stream handshakes, sequencer, state
// registers, transmit-queue RAM. Depends on usart_pkg, usart_exec, usart_txq_ram.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / tready | tuser: mode; tdata: addr, wdata, rx
//  m_axis   | out       | m_axis_tvalid / tready | tdata: one result per event
//
// Each event passes through the accept cycle (IDLE), execute (EXEC; queue RAM read
// data is registered from the head address), then the output register (OUT). A
// new event is taken the cycle after the result transfer, so only one event is in
// flight and any output stall holds off the input.
// Reset (rst_ni low, asynchronous) clears the sequencer state and register file; frame resets to 6.
// The queue RAM has no reset; only entries already written are ever used.
module usart_register_model (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [2:0] reg_addr, [10:3] write_data, [18:11] rx_char
  input  logic [2:0]  s_axis_tuser,  // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [7:0] read_data, [8] rx_irq, [9] tx_irq,
                                     // [10] udre_irq, [11] tx_char_valid, [19:12] tx_char,
                                     // [20] tx_line_active, [21] rx_listening,
                                     // [22] start_tx_timer, [23] start_rx_timer,
                                     // [44:24] baud_divisor
);
  import usart_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } fsm_e;

  fsm_e    state_q, state_d;
  item_t   item_q;
  regs_t   regs_q, regs_next;
  result_t res_q, res_next;
  qwrite_t qwr;
  logic [7:0] q_rdata;
  logic       in_xfer, out_xfer;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;

  // Sequencer: take one event, execute it, hold the result until taken
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer)  state_d = ST_EXEC;
      ST_EXEC: state_d = ST_OUT;
      ST_OUT:  if (out_xfer) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the event payload on the input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.mode       <= s_axis_tuser;
      item_q.reg_addr   <= s_axis_tdata[2:0];
      item_q.write_data <= s_axis_tdata[10:3];
      item_q.rx_char    <= s_axis_tdata[18:11];
    end
  end

  // Register file: commit the execute result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{frame: FRAME_RESET, default: '0};
    end else if (state_q == ST_EXEC) begin
      regs_q <= regs_next;
    end
  end

  // Output register: hold the result until the master side takes it
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXEC) begin
      res_q <= res_next;
    end
  end

  // Queue RAM: read the head slot every cycle; the head only moves in EXEC,
  // and a push in EXEC lands before the read for the next EXEC is registered
  usart_txq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (8)
  ) u_txq_ram (
    .clk_i   (clk_i),
    .we_i    (qwr.we && (state_q == ST_EXEC)),
    .waddr_i (qwr.addr),
    .wdata_i (qwr.data),
    .raddr_i (ptr_slot(regs_q.rd_ptr)),
    .rdata_o (q_rdata)
  );

  usart_exec u_exec (
    .item_i    (item_q),
    .regs_i    (regs_q),
    .q_rdata_i (q_rdata),
    .regs_o    (regs_next),
    .res_o     (res_next),
    .qwr_o     (qwr)
  );

  assign m_axis_tdata = {3'b000, res_q};

endmodule

[rtl/usart_chk.sv]
// Port-level checker for the USART register model, bound to the top level.
// Depends only on the top level's ports.
module usart_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // One event in flight: no new input while a result waits
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  // An accepted event blocks the input while it executes, then yields a result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (!s_axis_tready ##1 m_axis_tvalid))
    else $error("result did not follow an accepted event");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Transmit byte is zero unless handed to the line; divisor is a multiple of 8
  a_txchar_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[11] || (m_axis_tdata[19:12] == 8'h00))
                       && (m_axis_tdata[26:24] == 3'b000)))
    else $error("tx byte without valid or malformed baud divisor");

endmodule

bind usart_register_model usart_chk u_usart_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for usart_register_model: streams bus accesses and serial
// events into the block and checks every result against a predictor of the register
// file. Depends on usart_pkg and the RTL top level.

import usart_pkg::*;

// Predicts the register file and holds the results still owed by the block.
class usart_event_board;
  logic [7:0]  status, control, frame, baud_lo, baud_hi, rx_data;
  logic [7:0]  txq [QUEUE_DEPTH];
  int unsigned wr_ptr, rd_ptr;
  bit          listen, line;
  result_t     owed_q[$];
  int unsigned fail_count;
  int unsigned result_idx;

  function new();
    status     = '0;
    control    = '0;
    frame      = FRAME_RESET;
    baud_lo    = '0;
    baud_hi    = '0;
    rx_data    = '0;
    wr_ptr     = 0;
    rd_ptr     = 0;
    listen     = 1'b0;
    line       = 1'b0;
    fail_count = 0;
    result_idx = 0;
  endfunction

  function int unsigned fill();
    return (wr_ptr + 2 * QUEUE_DEPTH - rd_ptr) % (2 * QUEUE_DEPTH);
  endfunction

  function int unsigned pending();
    return owed_q.size();
  endfunction

  // Apply one accepted event to the shadow registers and queue its result.
  function void note_event(input item_t it);
    result_t     r;
    logic [7:0]  diff;
    int unsigned base;
    r = '0;
    case (it.mode)
      MODE_READ: begin
        case (it.reg_addr)
          ADDR_STATUS:  r.read_data = status;
          ADDR_CONTROL: r.read_data = control;
          ADDR_FRAME:   r.read_data = frame;
          ADDR_BAUD_LO: r.read_data = baud_lo;
          ADDR_BAUD_HI: r.read_data = baud_hi;
          ADDR_DATA: begin
            r.read_data    = rx_data;
            status[ST_RXC] = 1'b0;
            if (control[CT_RXEN]) listen = 1'b1;
          end
          default: ;
        endcase
      end
      MODE_WRITE: begin
        case (it.reg_addr)
          ADDR_STATUS: status = {3'b000, it.write_data[4:0]};
          ADDR_CONTROL: begin
            diff    = control ^ it.write_data;
            control = it.write_data;
            if (it.write_data[CT_TXEN] && diff[CT_TXEN]) status[ST_UDRE] = 1'b1;
            if (diff[CT_RXEN]) listen = it.write_data[CT_RXEN];
          end
          ADDR_FRAME:   frame   = it.write_data;
          ADDR_BAUD_LO: baud_lo = it.write_data;
          ADDR_BAUD_HI: baud_hi = it.write_data;
          ADDR_DATA: begin
            if (status[ST_UDRE] && fill() < QUEUE_DEPTH) begin
              status[ST_TXC]           = 1'b0;
              status[ST_UDRE]          = 1'b0;
              line                     = 1'b1;
              txq[wr_ptr % QUEUE_DEPTH] = it.write_data;
              wr_ptr                   = (wr_ptr + 1) % (2 * QUEUE_DEPTH);
              r.start_tx_timer         = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_RX_BYTE: begin
        if (status[ST_RXC]) begin
          status[ST_DOR] = 1'b1;
        end else begin
          rx_data        = it.rx_char;
          status[ST_RXC] = 1'b1;
        end
        r.start_rx_timer = 1'b1;
        listen           = 1'b0;
      end
      MODE_RX_HOLD: if (control[CT_RXEN]) listen = 1'b1;
      MODE_TX_TIMER: begin
        if (fill() >= QUEUE_DEPTH) begin
          r.start_tx_timer = 1'b1;
        end else begin
          status[ST_UDRE] = 1'b1;
          status[ST_TXC]  = 1'b1;
        end
      end
      MODE_LINE_PULL: begin
        if (fill() > 0) begin
          r.tx_char       = txq[rd_ptr % QUEUE_DEPTH];
          r.tx_char_valid = 1'b1;
          rd_ptr          = (rd_ptr + 1) % (2 * QUEUE_DEPTH);
        end
        if (fill() == 0) line = 1'b0;
      end
      MODE_TXC_ACK: status[ST_TXC] = 1'b0;
      default: ;
    endcase
    base             = {baud_hi, baud_lo} + 1;
    r.baud_divisor   = DIV_W'((status[ST_U2X] ? 8 : 16) * base);
    r.rx_irq         = status[ST_RXC] & control[CT_RXCIE];
    r.tx_irq         = status[ST_TXC] & control[CT_TXCIE];
    r.udre_irq       = status[ST_UDRE] & control[CT_UDRIE];
    r.tx_line_active = line;
    r.rx_listening   = listen;
    owed_q.push_back(r);
  endfunction

  function void flag(input string field, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("result %0d, %s: expected 0x%0h, actual 0x%0h", result_idx, field, want, got);
  endfunction

  function void compare(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) flag(field, want, got);
  endfunction

  // Check one transferred result, field by field, against the oldest prediction.
  function void check_result(input logic [47:0] raw);
    result_t got, want;
    got = result_t'(raw[44:0]);
    if (owed_q.size() == 0) begin
      flag("result with no event outstanding", '0, raw[31:0]);
    end else begin
      want = owed_q.pop_front();
      compare("read_data", want.read_data, got.read_data);
      compare("rx_irq", want.rx_irq, got.rx_irq);
      compare("tx_irq", want.tx_irq, got.tx_irq);
      compare("udre_irq", want.udre_irq, got.udre_irq);
      compare("tx_char_valid", want.tx_char_valid, got.tx_char_valid);
      compare("tx_char", want.tx_char, got.tx_char);
      compare("tx_line_active", want.tx_line_active, got.tx_line_active);
      compare("rx_listening", want.rx_listening, got.rx_listening);
      compare("start_tx_timer", want.start_tx_timer, got.start_tx_timer);
      compare("start_rx_timer", want.start_rx_timer, got.start_rx_timer);
      compare("baud_divisor", want.baud_divisor, got.baud_divisor);
      compare("padding", '0, raw[47:45]);
    end
    result_idx++;
  endfunction
endclass

module tb;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Mode code outside the named events; the block must leave its state alone.
  localparam logic [2:0]  MODE_SPARE   = 3'd7;
  // Offsets with no register behind them.
  localparam logic [2:0]  ADDR_HOLE_LO = 3'd3;
  localparam logic [2:0]  ADDR_HOLE_HI = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [2:0] reg_addr, [10:3] write_data, [18:11] rx_char
  logic [2:0]  s_axis_tuser;   // [2:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [7:0] read_data ... [44:24] baud_divisor

  usart_event_board board;
  int unsigned      cycle_count;
  int unsigned      burst_left;
  int unsigned      sent;

  usart_register_model dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or stalls forever.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("usart_register_model: mismatch");
    $finish;
  end

  // Result side: check each transfer, then pick the ready level for the next edge.
  // The sink switches between stall styles: always ready, a rotating bit mask,
  // or mostly stalled.
  initial begin : result_sink
    logic [15:0] stall_mask;
    int unsigned phase;
    int unsigned style;
    m_axis_tready <= 1'b0;
    stall_mask = '1;
    phase      = 0;
    style      = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        board.check_result(m_axis_tdata);
      if (phase % 256 == 0) begin
        style      = $urandom_range(0, 2);
        stall_mask = 16'($urandom);
      end
      case (style)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= stall_mask[phase % 16];
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
      phase++;
    end
  end

  // Present one event and hold it until the transfer, then note it with the
  // predictor. The sender works in bursts; at the end of a burst drop valid
  // for a random gap, or carry straight on into the next burst.
  task automatic send_event(input logic [2:0] mode, input logic [2:0] addr,
                            input logic [7:0] wdata, input logic [7:0] rx_char);
    item_t       it;
    int unsigned gap;
    it.mode       = mode;
    it.reg_addr   = addr;
    it.write_data = wdata;
    it.rx_char    = rx_char;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b00000, rx_char, wdata, addr};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    board.note_event(it);
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Events whose other fields do not matter get random filler there.
  task automatic send_bare(input logic [2:0] mode);
    send_event(mode, 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_write(input logic [2:0] addr, input logic [7:0] wdata);
    send_event(MODE_WRITE, addr, wdata, 8'($urandom));
  endtask

  task automatic send_read(input logic [2:0] addr);
    send_event(MODE_READ, addr, 8'($urandom), 8'($urandom));
  endtask

  // Field extremes, every event kind and the corner cases, in a short fixed run.
  task automatic run_directed();
    send_read(ADDR_STATUS);
    send_read(ADDR_FRAME);
    send_read(ADDR_HOLE_LO);
    send_write(ADDR_HOLE_HI, 8'hFF);         // unmapped write, ignored
    send_read(ADDR_HOLE_HI);
    send_write(ADDR_DATA, 8'hA5);            // no UDRE yet: dropped
    send_write(ADDR_BAUD_LO, 8'hFF);
    send_write(ADDR_BAUD_HI, 8'hFF);         // largest divisor
    send_write(ADDR_STATUS, 8'hFF);          // top three flags forced low, U2X set
    send_read(ADDR_STATUS);
    send_write(ADDR_CONTROL, 8'hF8);         // all enables, TXEN rising sets UDRE
    send_write(ADDR_DATA, 8'h00);
    send_bare(MODE_TX_TIMER);
    send_write(ADDR_DATA, 8'hFF);
    send_bare(MODE_LINE_PULL);
    send_bare(MODE_LINE_PULL);
    send_bare(MODE_LINE_PULL);               // empty queue: nothing popped, line stays released
    send_bare(MODE_TXC_ACK);
    send_event(MODE_RX_BYTE, 3'($urandom), 8'($urandom), 8'hFF);
    send_event(MODE_RX_BYTE, 3'($urandom), 8'($urandom), 8'h00);  // overrun
    send_read(ADDR_DATA);
    send_bare(MODE_RX_HOLD);
    send_write(ADDR_CONTROL, 8'h00);         // receiver off stops listening
    send_bare(MODE_RX_HOLD);                 // no RXEN: stays deaf
    send_bare(MODE_SPARE);
    send_write(ADDR_FRAME, 8'h00);
  endtask

  // One random sequence. Most are well-formed transmit or receive exchanges with
  // random content; the rest retune registers or throw in arbitrary events.
  task automatic run_random_sequence();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  ctl;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // Fill the queue; now and then run it past full.
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
      repeat (n) begin
        send_write(ADDR_DATA, 8'($urandom));
        if ($urandom_range(0, 5) != 0) send_bare(MODE_TX_TIMER);
      end
    end else if (pick < 45) begin
      // Drain toward empty, with the odd timer expiry or interrupt acknowledge.
      n = $urandom_range(1, 12);
      repeat (n) begin
        send_bare(MODE_LINE_PULL);
        case ($urandom_range(0, 5))
          0:       send_bare(MODE_TXC_ACK);
          1:       send_bare(MODE_TX_TIMER);
          default: ;
        endcase
      end
    end else if (pick < 70) begin
      // Receive bytes: arrival, maybe an overrunning second one, hold-off, read.
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_event(MODE_RX_BYTE, 3'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0)
          send_event(MODE_RX_BYTE, 3'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 2) == 0) send_read(ADDR_STATUS);
        if ($urandom_range(0, 4) != 0) send_bare(MODE_RX_HOLD);
        if ($urandom_range(0, 4) != 0) send_read(ADDR_DATA);
      end
    end else if (pick < 85) begin
      // Retune a register, mostly keeping both directions enabled.
      ctl = 8'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        ctl[CT_RXEN] = 1'b1;
        ctl[CT_TXEN] = 1'b1;
      end
      case ($urandom_range(0, 5))
        0: send_write(ADDR_CONTROL, ctl);
        1: begin
          // Bounce TXEN to raise UDRE, then try a data write, full queue or not.
          ctl[CT_TXEN] = 1'b0;
          send_write(ADDR_CONTROL, ctl);
          ctl[CT_TXEN] = 1'b1;
          send_write(ADDR_CONTROL, ctl);
          send_write(ADDR_DATA, 8'($urandom));
        end
        2: send_write(ADDR_FRAME, 8'($urandom));
        3: send_write(ADDR_BAUD_LO, 8'($urandom));
        4: send_write(ADDR_BAUD_HI, 8'($urandom));
        default: send_write(ADDR_STATUS, 8'($urandom));
      endcase
      send_read(3'($urandom));
    end else begin
      // Arbitrary events, the spare mode code among them.
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 19) == 0)
          send_bare(MODE_SPARE);
        else
          send_event(3'($urandom_range(0, 6)), 3'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    board = new();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_READ;
    burst_left = 8;
    sent       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    sent = 0;
    while (sent < RANDOM_ITEMS) run_random_sequence();
    s_axis_tvalid <= 1'b0;

    // Wait for every owed result, then idle on for stray results before the final check.
    while (board.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (board.pending() != 0) board.flag("results never delivered", '0, board.pending());

    if (board.fail_count == 0) begin
      $display("usart_register_model: match");
    end else begin
      $display("usart_register_model: mismatch");
    end
    $finish;
  end

endmodule
